FILE: src/scr_pkg.sv
// shared types and constants for the segment clip block
// no dependencies
`default_nettype none
package scr_pkg;
    localparam int W = 16;
    typedef logic signed [W-1:0] coord_t;
    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } in_word_t;
    typedef struct packed {
        coord_t clip_x;
        coord_t clip_y;
        logic   end_outside;
    } out_word_t;
    typedef enum logic [1:0] {
        REG_MIN_X = 2'd0,
        REG_MIN_Y = 2'd1,
        REG_MAX_X = 2'd2,
        REG_MAX_Y = 2'd3
    } reg_idx_t;
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_CHECK,
        S_DIV,
        S_MUL,
        S_DONE
    } back_st_t;
    localparam logic signed [W-1:0] RST_MIN = -16'sd8192;
    localparam logic signed [W-1:0] RST_MAX = 16'sd8192;
endpackage
`default_nettype wire

FILE: src/scr_front.sv
// front: takes words, snapshots walls and classifies the end point
// depends on scr_pkg
`default_nettype none
module scr_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire scr_pkg::in_word_t in_word,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire scr_pkg::coord_t  min_x,
    input  wire scr_pkg::coord_t  min_y,
    input  wire scr_pkg::coord_t  max_x,
    input  wire scr_pkg::coord_t  max_y,
    output scr_pkg::in_word_t     q_word,
    output logic [4*scr_pkg::W-1:0] q_walls,
    output logic                  q_out,
    output logic                  q_valid,
    input  wire logic             q_stall
);
    import scr_pkg::*;
    // two-entry queue toward the back part
    in_word_t           w_reg [2];
    logic [4*W-1:0]     k_reg [2];
    logic               o_reg [2];
    logic [1:0]         cnt_reg;
    logic               rd_reg, wr_reg;
    logic push, pop, outside;

    assign outside = !(in_word.end_x >= min_x && in_word.end_y >= min_y &&
                       in_word.end_x <= max_x && in_word.end_y <= max_y);
    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && !q_stall;
    assign q_word = w_reg[rd_reg];
    assign q_walls = k_reg[rd_reg];
    assign q_out = o_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (push) wr_reg <= !wr_reg;
            if (pop) rd_reg <= !rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            w_reg[wr_reg] <= in_word;
            k_reg[wr_reg] <= {min_x, min_y, max_x, max_y};
            o_reg[wr_reg] <= outside;
        end
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue overflow");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> in_stall) else $error("full lost");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> (rd_reg == wr_reg)) else $error("pointer slip");
endmodule
`default_nettype wire

FILE: src/scr_back.sv
// back: sequential wall tests with a radix-2 divider, one wall at a time
// depends on scr_pkg
`default_nettype none
module scr_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire scr_pkg::in_word_t q_word,
    input  wire logic [4*scr_pkg::W-1:0] q_walls,
    input  wire logic             q_out,
    input  wire logic             q_valid,
    output logic                  q_stall,
    output scr_pkg::out_word_t    out_word,
    output logic                  out_valid,
    input  wire logic             out_stall
);
    import scr_pkg::*;
    localparam int DW = W + 2;     // differences
    localparam int PW = 2*DW + 2;  // cross products

    back_st_t st_reg, st_next;
    in_word_t w_reg;
    logic [4*W-1:0] k_reg;
    logic o_reg;
    logic [1:0] wall_reg;
    logic signed [PW-1:0] kk_reg, tn_reg, sn_reg, r_reg;
    logic [16:0] tq_reg;
    logic [4:0] it_reg;
    coord_t rx_reg, ry_reg;
    logic ov_reg;
    out_word_t ow_reg;

    coord_t minx, miny, maxx, maxy, q1x, q1y, q2x, q2y;
    logic signed [DW-1:0] dx, dy, ex, ey, qx, qy;
    logic signed [PW-1:0] kc, tc, sc;
    logic signed [PW-1:0] r2;
    logic signed [DW+18:0] px, py;

    assign {minx, miny, maxx, maxy} = k_reg;
    always_comb
    begin
        unique case (wall_reg)
            2'd0: begin q1x = minx; q1y = miny; q2x = minx; q2y = maxy; end
            2'd1: begin q1x = maxx; q1y = miny; q2x = maxx; q2y = maxy; end
            2'd2: begin q1x = minx; q1y = miny; q2x = maxx; q2y = miny; end
            default: begin q1x = minx; q1y = maxy; q2x = maxx; q2y = maxy; end
        endcase
    end
    assign dx = DW'(w_reg.end_x) - DW'(w_reg.start_x);
    assign dy = DW'(w_reg.end_y) - DW'(w_reg.start_y);
    assign ex = DW'(q2x) - DW'(q1x);
    assign ey = DW'(q2y) - DW'(q1y);
    assign qx = DW'(q1x) - DW'(w_reg.start_x);
    assign qy = DW'(q1y) - DW'(w_reg.start_y);
    assign kc = PW'(dy*ex) - PW'(dx*ey);
    assign tc = PW'(ex*qy) - PW'(ey*qx);
    assign sc = PW'(dx*qy) - PW'(dy*qx);
    assign r2 = r_reg <<< 1;
    assign px = ((DW+19)'(w_reg.start_x) <<< 16) + dx * $signed({1'b0, tq_reg});
    assign py = ((DW+19)'(w_reg.start_y) <<< 16) + dy * $signed({1'b0, tq_reg});

    assign q_stall = (st_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_word = ow_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:  if (q_valid) st_next = q_out ? S_SETUP : S_DONE;
            S_SETUP: st_next = S_CHECK;
            S_CHECK:
                if (kk_reg == 0 || tn_reg < 0 || sn_reg < 0 || tn_reg > kk_reg ||
                    sn_reg > kk_reg)
                    st_next = (wall_reg == 2'd3) ? S_DONE : S_SETUP;
                else
                    st_next = S_DIV;
            S_DIV:   if (it_reg == 5'd16 || tn_reg == kk_reg) st_next = S_MUL;
            S_MUL:   st_next = (wall_reg == 2'd3) ? S_DONE : S_SETUP;
            S_DONE:  if (!ov_reg || !out_stall) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == S_DONE && (!ov_reg || !out_stall))
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
                if (q_valid)
                begin
                    w_reg <= q_word; k_reg <= q_walls; o_reg <= q_out;
                    wall_reg <= 2'd0;
                    rx_reg <= q_word.end_x; ry_reg <= q_word.end_y;
                end
            S_SETUP:
            begin
                kk_reg <= (kc < 0) ? -kc : kc;
                tn_reg <= (kc < 0) ? -tc : tc;
                sn_reg <= (kc < 0) ? -sc : sc;
            end
            S_CHECK:
            begin
                r_reg <= tn_reg; tq_reg <= '0; it_reg <= '0;
                if (kk_reg == 0 || tn_reg < 0 || sn_reg < 0 || tn_reg > kk_reg ||
                    sn_reg > kk_reg)
                    wall_reg <= wall_reg + 2'd1;
            end
            S_DIV:
                if (tn_reg == kk_reg) tq_reg <= 17'h10000;
                else if (it_reg != 5'd16)
                begin
                    it_reg <= it_reg + 5'd1;
                    if (r2 >= kk_reg)
                    begin
                        r_reg <= r2 - kk_reg; tq_reg <= {tq_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= r2; tq_reg <= {tq_reg[15:0], 1'b0};
                    end
                end
            S_MUL:
            begin
                rx_reg <= px[W+15:16]; ry_reg <= py[W+15:16];
                wall_reg <= wall_reg + 2'd1;
            end
            S_DONE:
                if (!ov_reg || !out_stall)
                    ow_reg <= '{clip_x: rx_reg, clip_y: ry_reg, end_outside: o_reg};
            default: ;
        endcase
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> q_stall) else $error("queue popped while busy");
    a_it: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DIV) |-> (it_reg <= 5'd16)) else $error("divider overrun");
endmodule
`default_nettype wire

FILE: src/segment_clip_to_rectangle_core.sv
// top level: wall registers, front classifier and back clip engine
// depends on scr_pkg, scr_front, scr_back
// One result word per input word, in order. An end point inside the rectangle
// goes from idle straight to the done state of the back part; an outside one
// is tested against four walls in turn, each through setup and check, and a
// crossed wall also through a 16-step radix-2 divider for t and a multiply.
// A two-word queue lets the front keep accepting while the back part works.
`default_nettype none
module segment_clip_to_rectangle_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire scr_pkg::in_word_t     in_word,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output scr_pkg::out_word_t         out_word,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [scr_pkg::W-1:0] cfg_data
);
    import scr_pkg::*;
    coord_t min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    in_word_t q_word;
    logic [4*W-1:0] q_walls;
    logic q_out, q_valid, q_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= RST_MIN; min_y_reg <= RST_MIN;
            max_x_reg <= RST_MAX; max_y_reg <= RST_MAX;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MIN_X: min_x_reg <= W'(cfg_data);
                REG_MIN_Y: min_y_reg <= W'(cfg_data);
                REG_MAX_X: max_x_reg <= W'(cfg_data);
                REG_MAX_Y: max_y_reg <= W'(cfg_data);
                default: ;
            endcase
        end
    end

    scr_front u_front (
        .clk, .rst_n, .in_word, .in_valid, .in_stall,
        .min_x(min_x_reg), .min_y(min_y_reg), .max_x(max_x_reg), .max_y(max_y_reg),
        .q_word, .q_walls, .q_out, .q_valid, .q_stall
    );
    scr_back u_back (
        .clk, .rst_n, .q_word, .q_walls, .q_out, .q_valid, .q_stall,
        .out_word, .out_valid, .out_stall
    );
endmodule
`default_nettype wire
